@@ hdl/slse_pkg.sv @@
// Shared types and constants for the spike latency sample encoder.
// Holds field widths, register indexes, sequencer step codes and the control bundle.
// Depends on nothing; the top level, the sequencer and the bench import it.
package slse_pkg;

  // Fixed field widths of the ports.
  localparam int COORD_W    = 17;
  localparam int NOW_W      = 47;
  localparam int TICK_W     = 48;
  localparam int AMP_W      = 17;
  localparam int PAMP_W     = 15;
  localparam int LINE_W     = 3;
  localparam int CLASS_W    = 2;
  localparam int MLAT_W     = 10;
  localparam int EPI_W      = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  // Millisecond counts: a latency is at most 1024 and the class time at most 1028.
  localparam int MS_W = 11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAINING    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EPISODE     = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [MLAT_W-1:0] MLAT_RESET = 10'd100;

  // Sequencer steps of the calculation phase. A step issues one multiply-add and
  // captures the result issued by the step before it.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAT_X    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAT_XN   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAT_Y    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LAT_YN   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TICK_ONE = 4'd4;
  localparam logic [STEP_W-1:0] STEP_TICK_T0  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_TICK_T1  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_TICK_T2  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_TICK_T3  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_TICK_C   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST     = 4'd10;

  // Event numbering: two events per line, the last one depends on training.
  localparam int EV_W = 4;
  localparam logic [EV_W-1:0] EV_LAST_PLAIN = 4'd9;
  localparam logic [EV_W-1:0] EV_LAST_TRAIN = 4'd15;

  // Input lines.
  localparam logic [LINE_W-1:0] LINE_BIAS       = 3'd0;
  localparam logic [LINE_W-1:0] LINE_COORD0     = 3'd1;
  localparam logic [LINE_W-1:0] LINE_LAST_COORD = 3'd4;
  localparam logic [LINE_W-1:0] LINE_LABEL0     = 3'd5;

  // Class handling and the class pulse offset.
  localparam logic [CLASS_W-1:0] CLASS_MAX = 2'd2;
  localparam logic [MS_W-1:0]    TC_PAD_MS = 11'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEND,
    ST_DISP,
    ST_CALC,
    ST_EMIT
  } state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic              latch_in;
    logic              calc;
    logic [STEP_W-1:0] step;
    logic              emit;
    logic [EV_W-1:0]   ev;
    logic              emit_pend;
    logic              pend_hi;
    logic              store_pend;
  } ctl_t;

endpackage

@@ hdl/spike_latency_sample_encoder.sv @@
// Top level of the spike latency sample encoder: configuration registers, datapath, output.
// Depends on slse_pkg, slse_mac and slse_ctrl.
//
// A start item (func 0) arms the block; the next step item (func 1) carries a sample and
// produces ten stimulus events, or sixteen in training mode, one per cycle on the output
// register while the output is free. A sample first goes through the calculation steps, in
// which the single multiply-add unit works out the four latencies and the six tick times
// one product per cycle; the events follow. The block takes no new item until the current
// one is finished, and output backpressure stalls the emission. The class pulse pair of a
// training sample leaves at the start of the next item.
module spike_latency_sample_encoder #(
  parameter int TICKS_PER_MILLI = 1000,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [slse_pkg::NOW_W-1:0]        in_now_tick,
  input  logic [slse_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [slse_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [slse_pkg::CLASS_W-1:0]      in_sample_class,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [slse_pkg::LINE_W-1:0]       out_line_index,
  output logic signed [slse_pkg::AMP_W-1:0] out_amplitude,
  output logic [slse_pkg::TICK_W-1:0]       out_fire_tick,
  output logic                              out_last_event,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slse_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import slse_pkg::*;

  localparam int VW = COORD_FRAC_BITS + 1;
  localparam int XW = (VW > COORD_W) ? VW : COORD_W;
  localparam int TW = $clog2(TICKS_PER_MILLI + 1);
  localparam int AW = (VW > MS_W) ? VW : MS_W;
  localparam int BW = (TW > MLAT_W) ? TW : MLAT_W;

  localparam logic [VW-1:0]     ONE   = VW'(1) << COORD_FRAC_BITS;
  localparam logic [TICK_W-1:0] HALF  = TICK_W'(1) << (COORD_FRAC_BITS - 1);
  localparam logic [BW-1:0]     TPM_B = BW'(TICKS_PER_MILLI);
  localparam logic [TICK_W-1:0] TPM_T = TICK_W'(TICKS_PER_MILLI);

  ctl_t                ctl;
  logic                out_free;

  // Configuration registers.
  logic [MLAT_W-1:0]   mlat_r;
  logic [PAMP_W-1:0]   pamp_cfg_r;
  logic                train_r;
  logic [EPI_W-1:0]    episode_r;

  // Latched item.
  logic [NOW_W-1:0]    now_r;
  logic [VW-1:0]       vx_r, vy_r;
  logic [CLASS_W-1:0]  class_r;
  logic [XW-1:0]       xw, yw;

  // Calculation results.
  logic [MS_W-1:0]     t_r [4];
  logic [MS_W-1:0]     t_new, m1, m2, tc;
  logic [TICK_W-1:0]   tk1_r, tkc_r;
  logic [TICK_W-1:0]   tkt_r [4];

  // Held class events.
  logic [LINE_W-1:0]   pline_r;
  logic [PAMP_W:0]     pamp_r;
  logic [TICK_W-1:0]   ptick_r;

  // Shared unit operands.
  logic [AW-1:0]       mac_a;
  logic [BW-1:0]       mac_b;
  logic [TICK_W-1:0]   mac_c;
  logic [TICK_W-1:0]   mac_res;

  // Event being emitted.
  logic [LINE_W-1:0]   ev_line;
  logic [PAMP_W:0]     ev_mag;
  logic                ev_neg;
  logic [TICK_W-1:0]   ev_base, ev_add;
  logic                ev_last;

  // Output register.
  logic                out_valid_r;
  logic [LINE_W-1:0]   out_line_r;
  logic [AMP_W-1:0]    out_amp_r;
  logic [TICK_W-1:0]   out_tick_r;
  logic                out_last_r;

  slse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .train    (train_r),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  slse_mac #(
    .AW (AW),
    .BW (BW),
    .RW (TICK_W)
  ) u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .res (mac_res)
  );

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlat_r     <= MLAT_RESET;
      pamp_cfg_r <= '0;
      train_r    <= 1'b0;
      episode_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_LATENCY: mlat_r     <= cfg_data[MLAT_W-1:0];
        CFG_PULSE_AMP:   pamp_cfg_r <= cfg_data[PAMP_W-1:0];
        CFG_TRAINING:    train_r    <= cfg_data[0];
        CFG_EPISODE:     episode_r  <= cfg_data[EPI_W-1:0];
        default:         ;
      endcase
    end
  end

  // Coordinates above one saturate to one.
  assign xw = XW'(in_coord_x);
  assign yw = XW'(in_coord_y);

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      now_r   <= in_now_tick;
      vx_r    <= (xw > XW'(ONE)) ? ONE : VW'(xw);
      vy_r    <= (yw > XW'(ONE)) ? ONE : VW'(yw);
      class_r <= (in_sample_class > CLASS_MAX) ? CLASS_MAX : in_sample_class;
    end
  end

  // Class pulse time: later of the two per-axis earliest latencies, plus the pad.
  assign m1    = (t_r[0] < t_r[1]) ? t_r[0] : t_r[1];
  assign m2    = (t_r[2] < t_r[3]) ? t_r[2] : t_r[3];
  assign tc    = ((m1 > m2) ? m1 : m2) + TC_PAD_MS;
  assign t_new = MS_W'(mac_res >> COORD_FRAC_BITS) + MS_W'(1);

  // Operand selection for the shared unit.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    if (ctl.calc) begin
      case (ctl.step)
        STEP_LAT_X: begin
          mac_a = AW'(vx_r);
          mac_b = BW'(mlat_r);
          mac_c = HALF;
        end
        STEP_LAT_XN: begin
          mac_a = AW'(ONE - vx_r);
          mac_b = BW'(mlat_r);
          mac_c = HALF;
        end
        STEP_LAT_Y: begin
          mac_a = AW'(vy_r);
          mac_b = BW'(mlat_r);
          mac_c = HALF;
        end
        STEP_LAT_YN: begin
          mac_a = AW'(ONE - vy_r);
          mac_b = BW'(mlat_r);
          mac_c = HALF;
        end
        STEP_TICK_ONE: begin
          mac_a = AW'(1);
          mac_b = TPM_B;
          mac_c = TICK_W'(now_r);
        end
        STEP_TICK_T0: begin
          mac_a = AW'(t_r[0]);
          mac_b = TPM_B;
          mac_c = TICK_W'(now_r);
        end
        STEP_TICK_T1: begin
          mac_a = AW'(t_r[1]);
          mac_b = TPM_B;
          mac_c = TICK_W'(now_r);
        end
        STEP_TICK_T2: begin
          mac_a = AW'(t_r[2]);
          mac_b = TPM_B;
          mac_c = TICK_W'(now_r);
        end
        STEP_TICK_T3: begin
          mac_a = AW'(t_r[3]);
          mac_b = TPM_B;
          mac_c = TICK_W'(now_r);
        end
        STEP_TICK_C: begin
          mac_a = AW'(tc);
          mac_b = TPM_B;
          mac_c = TICK_W'(now_r);
        end
        default: ;
      endcase
    end
  end

  // Capture the result issued by the step before.
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      case (ctl.step)
        STEP_LAT_XN:   t_r[0]   <= t_new;
        STEP_LAT_Y:    t_r[1]   <= t_new;
        STEP_LAT_YN:   t_r[2]   <= t_new;
        STEP_TICK_ONE: t_r[3]   <= t_new;
        STEP_TICK_T0:  tk1_r    <= mac_res;
        STEP_TICK_T1:  tkt_r[0] <= mac_res;
        STEP_TICK_T2:  tkt_r[1] <= mac_res;
        STEP_TICK_T3:  tkt_r[2] <= mac_res;
        STEP_TICK_C:   tkt_r[3] <= mac_res;
        STEP_LAST:     tkc_r    <= mac_res;
        default: ;
      endcase
    end
  end

  // Hold the class pulse pair for the next item.
  always_ff @(posedge clk) begin
    if (ctl.store_pend) begin
      pline_r <= LINE_LABEL0 + LINE_W'(class_r);
      pamp_r  <= {pamp_cfg_r, 1'b0};
      ptick_r <= tkc_r;
    end
  end

  // Event fields: pairs of events share a line, the odd one ends the pulse.
  always_comb begin
    logic [LINE_W-1:0] pair;
    logic [LINE_W-1:0] cidx;
    logic              odd;
    pair    = ctl.ev[EV_W-1:1];
    odd     = ctl.ev[0];
    cidx    = pair - LINE_COORD0;
    ev_line = pair;
    ev_mag  = {1'b0, pamp_cfg_r};
    ev_neg  = odd;
    ev_base = tk1_r;
    ev_add  = odd ? TPM_T : '0;
    ev_last = 1'b0;
    if (ctl.emit_pend) begin
      ev_line = pline_r;
      ev_mag  = pamp_r;
      ev_neg  = ctl.pend_hi;
      ev_base = ptick_r;
      ev_add  = ctl.pend_hi ? TPM_T : '0;
      ev_last = ctl.pend_hi;
    end else if (pair == LINE_BIAS) begin
      ev_base = tk1_r;
    end else if (pair < LINE_LABEL0) begin
      ev_base = tkt_r[cidx[1:0]];
      ev_last = odd && !train_r && (pair == LINE_LAST_COORD);
    end else begin
      // Label lines: inhibit now, release after the episode.
      ev_neg = !odd;
      ev_add = odd ? TICK_W'(episode_r) : '0;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit || ctl.emit_pend) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload of the transfer.
  always_ff @(posedge clk) begin
    if (ctl.emit || ctl.emit_pend) begin
      out_line_r <= ev_line;
      out_amp_r  <= ev_neg ? (AMP_W'(0) - AMP_W'(ev_mag)) : AMP_W'(ev_mag);
      out_tick_r <= ev_base + ev_add;
      out_last_r <= ev_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_index = out_line_r;
  assign out_amplitude  = out_amp_r;
  assign out_fire_tick  = out_tick_r;
  assign out_last_event = out_last_r;

endmodule

@@ hdl/slse_mac.sv @@
// Shared multiply-add unit of the spike latency sample encoder.
// Computes a*b + c and registers the result; used for latencies and tick times.
// Depends on nothing.
module slse_mac #(
  parameter int AW = 17,
  parameter int BW = 10,
  parameter int RW = 48
) (
  input  logic          clk,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  input  logic [RW-1:0] c,
  output logic [RW-1:0] res
);

  logic [AW+BW-1:0] prod;
  logic [RW-1:0]    res_r;
  logic [RW-1:0]    res_nxt;

  // Product, widened addend sum.
  assign prod    = (AW+BW)'(a) * (AW+BW)'(b);
  assign res_nxt = RW'(prod) + c;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

@@ hdl/slse_ctrl.sv @@
// Sequencer of the spike latency sample encoder.
// Tracks the armed flag and pending class events, and steps the shared unit and emission.
// Depends on slse_pkg.
module slse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  input  logic          train,
  input  logic          out_free,
  output logic          in_ready,
  output slse_pkg::ctl_t ctl
);
  import slse_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [EV_W-1:0]   ev_r, ev_nxt;
  logic              pidx_r, pidx_nxt;
  logic              func_r, func_nxt;
  logic              armed_r, armed_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [EV_W-1:0]   ev_last;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      ev_r         <= '0;
      pidx_r       <= 1'b0;
      func_r       <= 1'b0;
      armed_r      <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      ev_r         <= ev_nxt;
      pidx_r       <= pidx_nxt;
      func_r       <= func_nxt;
      armed_r      <= armed_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  assign ev_last = train ? EV_LAST_TRAIN : EV_LAST_PLAIN;

  // Next state and control outputs.
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    ev_nxt         = ev_r;
    pidx_nxt       = pidx_r;
    func_nxt       = func_r;
    armed_nxt      = armed_r;
    pend_valid_nxt = pend_valid_r;
    in_ready       = 1'b0;
    ctl            = '0;
    ctl.step       = step_r;
    ctl.ev         = ev_r;
    ctl.pend_hi    = pidx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          func_nxt     = in_func;
          pidx_nxt     = 1'b0;
          state_nxt    = pend_valid_r ? ST_PEND : ST_DISP;
        end
      end
      // Class events held over from the previous sample go out first.
      ST_PEND: begin
        if (out_free) begin
          ctl.emit_pend = 1'b1;
          if (pidx_r) begin
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_DISP;
          end else begin
            pidx_nxt = 1'b1;
          end
        end
      end
      ST_DISP: begin
        if (!func_r) begin
          armed_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!armed_r) begin
          state_nxt = ST_IDLE;
        end else begin
          step_nxt  = STEP_LAT_X;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        ctl.calc = 1'b1;
        if (step_r == STEP_LAST) begin
          ev_nxt    = '0;
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl.emit = 1'b1;
          if (ev_r == ev_last) begin
            armed_nxt      = 1'b0;
            ctl.store_pend = train;
            if (train) begin
              pend_valid_nxt = 1'b1;
            end
            state_nxt = ST_IDLE;
          end else begin
            ev_nxt = ev_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ bench/slse_checker.sv @@
// Function codes shared by the bench, and the result checker of the spike latency encoder.
// The checker watches the three channels, predicts the stimulus events and compares them.
// Depends on slse_pkg for the port widths, register indexes and line numbers.
package slse_tb_pkg;

  // Codes of the input item's func field.
  localparam logic FUNC_ARM  = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

endpackage

module slse_checker #(
  parameter int TICKS_PER_MILLI = 1000,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_func,
  input  logic [slse_pkg::NOW_W-1:0]        in_now_tick,
  input  logic [slse_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [slse_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [slse_pkg::CLASS_W-1:0]      in_sample_class,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [slse_pkg::LINE_W-1:0]       out_line_index,
  input  logic signed [slse_pkg::AMP_W-1:0] out_amplitude,
  input  logic [slse_pkg::TICK_W-1:0]       out_fire_tick,
  input  logic                              out_last_event,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [slse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                mismatch_count,
  output int                                results_due
);

  import slse_pkg::*;
  import slse_tb_pkg::*;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [AMP_W-1:0]  amp;
    logic [TICK_W-1:0] tick;
    logic              last;
  } stim_event_t;

  // Events predicted but not yet seen, oldest first.
  stim_event_t due_events[$];

  // The class pulse pair of a training sample waits for the next item.
  stim_event_t held_pulses[2];
  int          held_count = 0;

  logic              sample_armed = 1'b0;
  logic [MLAT_W-1:0] lat_scale    = MLAT_RESET;
  logic [PAMP_W-1:0] amp_level    = '0;
  logic              train_on     = 1'b0;
  logic [EPI_W-1:0]  episode_len  = '0;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  function automatic logic [TICK_W-1:0] tick_at(input logic [63:0] base, input logic [63:0] ms);
    return TICK_W'(base + ms * 64'(TICKS_PER_MILLI));
  endfunction

  // Rounded latency in milliseconds of one coordinate; ties round up.
  function automatic logic [63:0] latency_of(input logic [63:0] v);
    logic [63:0] half;
    half = 64'd1 << (COORD_FRAC_BITS - 1);
    return ((v * 64'(lat_scale) + half) >> COORD_FRAC_BITS) + 64'd1;
  endfunction

  task automatic add_event(input logic [LINE_W-1:0] line, input logic [AMP_W-1:0] amp,
                           input logic [TICK_W-1:0] tick, input logic last);
    stim_event_t ev;
    ev.line = line;
    ev.amp  = amp;
    ev.tick = tick;
    ev.last = last;
    due_events.insert(due_events.size(), ev);
  endtask

  // Work out the events of one armed step item and disarm.
  task automatic encode_sample(input logic [NOW_W-1:0] now, input logic [COORD_W-1:0] cx,
                               input logic [COORD_W-1:0] cy, input logic [CLASS_W-1:0] cls);
    logic [63:0]       one;
    logic [63:0]       now64;
    logic [63:0]       x;
    logic [63:0]       y;
    logic [63:0]       lat [4];
    logic [63:0]       m_x;
    logic [63:0]       m_y;
    logic [63:0]       tc;
    logic [AMP_W-1:0]  a;
    logic [AMP_W-1:0]  na;
    logic [AMP_W-1:0]  a2;
    logic [AMP_W-1:0]  na2;
    logic [CLASS_W-1:0] c;
    one   = 64'd1 << COORD_FRAC_BITS;
    now64 = 64'(now);
    x     = 64'(cx);
    y     = 64'(cy);
    if (x > one) x = one;
    if (y > one) y = one;
    c = (cls > CLASS_MAX) ? CLASS_MAX : cls;
    lat[0] = latency_of(x);
    lat[1] = latency_of(one - x);
    lat[2] = latency_of(y);
    lat[3] = latency_of(one - y);
    m_x = (lat[0] < lat[1]) ? lat[0] : lat[1];
    m_y = (lat[2] < lat[3]) ? lat[2] : lat[3];
    tc  = ((m_x > m_y) ? m_x : m_y) + 64'(TC_PAD_MS);
    a   = AMP_W'(amp_level);
    na  = -a;
    a2  = a << 1;
    na2 = -a2;

    // Bias pair, then an on/off pair per coordinate line.
    add_event(LINE_BIAS, a, tick_at(now64, 64'd1), 1'b0);
    add_event(LINE_BIAS, na, tick_at(now64, 64'd2), 1'b0);
    for (int k = 0; k < 4; k++) begin
      add_event(LINE_COORD0 + LINE_W'(k), a, tick_at(now64, lat[k]), 1'b0);
      add_event(LINE_COORD0 + LINE_W'(k), na, tick_at(now64, lat[k] + 64'd1),
                !train_on && k == 3);
    end

    // Label inhibit/release pairs; the class pulse pair is held back.
    if (train_on) begin
      for (int k = 0; k < 3; k++) begin
        add_event(LINE_LABEL0 + LINE_W'(k), na, tick_at(now64, 64'd1), 1'b0);
        add_event(LINE_LABEL0 + LINE_W'(k), a, tick_at(now64 + 64'(episode_len), 64'd1), 1'b0);
      end
      held_pulses[0].line = LINE_LABEL0 + LINE_W'(c);
      held_pulses[0].amp  = a2;
      held_pulses[0].tick = tick_at(now64, tc);
      held_pulses[0].last = 1'b0;
      held_pulses[1].line = LINE_LABEL0 + LINE_W'(c);
      held_pulses[1].amp  = na2;
      held_pulses[1].tick = tick_at(now64, tc + 64'd1);
      held_pulses[1].last = 1'b1;
      held_count = 2;
    end
    sample_armed = 1'b0;
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic check_result();
    stim_event_t want;
    if (due_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event line %0d amp %0d tick %0d last %0b",
                                out_line_index, out_amplitude, out_fire_tick, out_last_event));
      return;
    end
    want = due_events.pop_front();
    if (out_line_index !== want.line) begin
      report_mismatch($sformatf("line_index %0d, expected %0d", out_line_index, want.line));
    end
    if (out_amplitude !== want.amp) begin
      report_mismatch($sformatf("amplitude %0d, expected %0d", out_amplitude,
                                $signed(want.amp)));
    end
    if (out_fire_tick !== want.tick) begin
      report_mismatch($sformatf("fire_tick %0d, expected %0d", out_fire_tick, want.tick));
    end
    if (out_last_event !== want.last) begin
      report_mismatch($sformatf("last_event %0b, expected %0b", out_last_event, want.last));
    end
  endtask

  // Results are checked before a new item is predicted within the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      due_events.delete();
      held_count   = 0;
      sample_armed = 1'b0;
      lat_scale    = MLAT_RESET;
      amp_level    = '0;
      train_on     = 1'b0;
      episode_len  = '0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_LATENCY: lat_scale   = cfg_data[MLAT_W-1:0];
          CFG_PULSE_AMP:   amp_level   = cfg_data[PAMP_W-1:0];
          CFG_TRAINING:    train_on    = cfg_data[0];
          CFG_EPISODE:     episode_len = cfg_data[EPI_W-1:0];
          default: ;
        endcase
      end

      // Held class pulses leave first on any item transfer.
      if (in_valid && in_ready) begin
        for (int k = 0; k < held_count; k++) begin
          due_events.insert(due_events.size(), held_pulses[k]);
        end
        held_count = 0;
        if (in_func == FUNC_ARM) begin
          sample_armed = 1'b1;
        end else if (sample_armed) begin
          encode_sample(in_now_tick, in_coord_x, in_coord_y, in_sample_class);
        end
      end
    end
    results_due = due_events.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Bench top of the spike latency sample encoder: clock, reset, stimulus and verdict.
// Depends on slse_pkg, slse_tb_pkg and slse_checker, which predicts and compares the events.
module tb_top;

  import slse_pkg::*;
  import slse_tb_pkg::*;

  localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_func;
  logic [NOW_W-1:0]           in_now_tick;
  logic [COORD_W-1:0]         in_coord_x;
  logic [COORD_W-1:0]         in_coord_y;
  logic [CLASS_W-1:0]         in_sample_class;
  logic                       out_valid;
  logic                       out_ready;
  logic [LINE_W-1:0]          out_line_index;
  logic signed [AMP_W-1:0]    out_amplitude;
  logic [TICK_W-1:0]          out_fire_tick;
  logic                       out_last_event;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  int                         mismatch_count;
  int                         results_due;

  // Stimulus bookkeeping: calm turns all idling off near the end.
  bit   calm        = 1'b0;
  bit   block_armed = 1'b0;
  int   useful      = 0;
  int   stall_left  = 0;
  int   quiet_left  = 0;

  always #5 clk = ~clk;

  spike_latency_sample_encoder uut (.*);

  slse_checker chk (.*);

  // Receiver side: random stall bursts, quiet stretches between them.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (quiet_left > 0) begin
      out_ready  <= 1'b1;
      quiet_left <= quiet_left - 1;
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          out_ready  <= 1'b0;
          stall_left <= $urandom_range(0, 16);
        end
        1: begin
          out_ready  <= 1'b1;
          quiet_left <= $urandom_range(10, 60);
        end
        default: out_ready <= 1'b1;
      endcase
    end
  end

  function automatic logic [NOW_W-1:0] rand_now();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return NOW_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_ONE;
      2: return COORD_W'($urandom);
      3: return COORD_ONE - COORD_W'($urandom_range(1, 8));
      default: return COORD_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // One input transfer, after an optional idle burst; valid stays up afterwards.
  task automatic offer(input logic func, input logic [NOW_W-1:0] now,
                       input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                       input logic [CLASS_W-1:0] cls);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_now_tick     <= now;
    in_coord_x      <= cx;
    in_coord_y      <= cy;
    in_sample_class <= cls;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Only items that arm or fire count toward the run length.
    if (func == FUNC_ARM) begin
      if (!block_armed) useful++;
      block_armed = 1'b1;
    end else if (block_armed) begin
      useful++;
      block_armed = 1'b0;
    end
  endtask

  task automatic offer_random(input logic func);
    offer(func, rand_now(), rand_coord(), rand_coord(), CLASS_W'($urandom_range(0, 3)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [MLAT_W-1:0] mlat, input logic [PAMP_W-1:0] amp,
                           input logic train, input logic [EPI_W-1:0] episode);
    write_reg(CFG_MAX_LATENCY, CFG_DATA_W'(mlat));
    write_reg(CFG_PULSE_AMP, CFG_DATA_W'(amp));
    write_reg(CFG_TRAINING, CFG_DATA_W'(train));
    write_reg(CFG_EPISODE, CFG_DATA_W'(episode));
  endtask

  // Drop valid, wait for every predicted event, then let the block go quiet.
  task automatic settle(input int cycles);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    logic [MLAT_W-1:0] mlat;
    logic [PAMP_W-1:0] amp;
    logic [EPI_W-1:0]  episode;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_ARM;
    in_now_tick     <= '0;
    in_coord_x      <= '0;
    in_coord_y      <= '0;
    in_sample_class <= '0;
    out_ready       <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_MAX_LATENCY;
    cfg_data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one plain sample at the coordinate extremes.
    offer(FUNC_ARM, '0, '0, '0, '0);
    offer(FUNC_STEP, '0, '0, COORD_ONE, 2'd0);
    settle(40);

    // Largest scale and amplitude, training on, longest episode.
    write_all('1, '1, 1'b1, '1);
    offer(FUNC_STEP, '1, 17'd123, 17'd456, 2'd1);
    offer(FUNC_ARM, rand_now(), rand_coord(), rand_coord(), 2'd0);
    offer(FUNC_ARM, rand_now(), rand_coord(), rand_coord(), 2'd1);
    offer(FUNC_STEP, '1, COORD_ONE, '0, 2'd2);
    // An arm item releases the held class pulses.
    offer(FUNC_ARM, rand_now(), rand_coord(), rand_coord(), 2'd2);
    // Saturated coordinates and the out-of-range class.
    offer(FUNC_STEP, rand_now(), '1, '1, 2'd3);
    // A step while disarmed still releases the held pulses.
    offer(FUNC_STEP, rand_now(), rand_coord(), rand_coord(), 2'd0);
    // Half-way coordinate with an odd scale lands on a rounding tie.
    offer(FUNC_ARM, rand_now(), rand_coord(), rand_coord(), 2'd0);
    offer(FUNC_STEP, rand_now(), 17'h08000, 17'd1, 2'd1);
    offer(FUNC_ARM, rand_now(), rand_coord(), rand_coord(), 2'd0);
    offer(FUNC_STEP, rand_now(), 17'd1, 17'h0FFFF, 2'd0);
    settle(40);

    // Smallest scale, zero amplitude, training off; the held pair crosses the write.
    write_all(10'd1, '0, 1'b0, '0);
    offer(FUNC_ARM, rand_now(), rand_coord(), rand_coord(), 2'd0);
    offer(FUNC_STEP, rand_now(), 17'h08000, 17'h07FFF, 2'd0);
    offer(FUNC_ARM, rand_now(), rand_coord(), rand_coord(), 2'd0);
    offer(FUNC_STEP, '0, COORD_ONE, '0, 2'd3);

    // Random phases, each under its own settings; the last one runs without idling.
    block_armed = 1'b0;
    for (int phase = 0; phase < 8; phase++) begin
      settle(40);
      case (phase)
        0, 3: mlat = '1;
        1, 2: mlat = 10'd1;
        default: mlat = MLAT_W'($urandom_range(1, 1023));
      endcase
      case ($urandom_range(0, 2))
        0: amp = '0;
        1: amp = '1;
        default: amp = PAMP_W'($urandom_range(0, 32767));
      endcase
      case ($urandom_range(0, 3))
        0: episode = '0;
        1: episode = '1;
        default: episode = EPI_W'({$urandom, $urandom});
      endcase
      write_all(mlat, amp, phase % 2 == 0, episode);
      calm   = (phase == 7);
      useful = 0;
      while (useful < 44) begin
        case ($urandom_range(0, 9))
          0: offer_random(logic'($urandom_range(0, 1)));
          1: begin
            offer_random(FUNC_ARM);
            offer_random(FUNC_ARM);
            offer_random(FUNC_STEP);
          end
          2: begin
            offer_random(FUNC_STEP);
            offer_random(FUNC_ARM);
            offer_random(FUNC_STEP);
          end
          default: begin
            offer_random(FUNC_ARM);
            offer_random(FUNC_STEP);
          end
        endcase
      end
    end
    // A last arm item lets any held class pulses out.
    offer_random(FUNC_ARM);
    settle(64);

    if (mismatch_count == 0) begin
      $display("** spike_latency_sample_encoder: PASSED **");
    end else begin
      $display("** spike_latency_sample_encoder: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("** spike_latency_sample_encoder: FAILED **");
    $finish;
  end

endmodule
